// File: hdl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM page master.
package i2cee_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } i2cee_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_NO_ACK  = 2'd2
  } i2cee_status_e;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_START = 7'b0000010,
    PH_SEND  = 7'b0000100,
    PH_ACK   = 7'b0001000,
    PH_RECV  = 7'b0010000,
    PH_MACK  = 7'b0100000,
    PH_STOP  = 7'b1000000
  } i2cee_phase_e;

  typedef enum logic [3:0] {
    STG_DEVW = 4'b0001,
    STG_ADDR = 4'b0010,
    STG_DATA = 4'b0100,
    STG_DEVR = 4'b1000
  } i2cee_stage_e;

  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CFG_ACK_POLL_LIMIT = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_DEVICE_ADDRESS = 2'd1;

  localparam logic [7:0] ACK_POLL_RESET = 8'd10;
  localparam logic [6:0] DEV_ADDR_RESET = 7'd80;
  localparam logic [7:0] MSB_MASK       = 8'h80;

  typedef struct packed {
    i2cee_op_e  operation;
    logic       sda_sample;
    logic [7:0] word_address;
    logic [7:0] length;
    logic [7:0] write_data;
  } i2cee_in_t;

  typedef struct packed {
    logic          scl;
    logic          sda_release;
    logic          busy_res;
    logic          done_res;
    i2cee_status_e status;
    logic [7:0]    read_data;
    logic          read_valid;
    logic          read_last;
  } i2cee_out_t;

  typedef struct packed {
    logic load;
    logic clear;
  } i2cee_buf_req_t;

endpackage

// File: hdl/i2cee_page_buf.sv
// Page buffer memory with fill count and registered read port.
module i2cee_page_buf import i2cee_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 16,
  localparam int unsigned IdxW = $clog2(PAGE_BYTES),
  localparam int unsigned CntW = $clog2(PAGE_BYTES + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  i2cee_buf_req_t req_i,
  input  logic [7:0]     wdata_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [7:0]     rd_data_o,
  output logic [CntW-1:0] load_count_o
);

  logic [7:0]      mem [PAGE_BYTES];
  logic [CntW-1:0] load_count_q, load_count_d;
  logic [7:0]      rd_data_q;

  always_comb begin
    load_count_d = load_count_q;
    if (req_i.clear) begin
      load_count_d = '0;
    end else if (req_i.load) begin
      load_count_d = load_count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
    end else begin
      load_count_q <= load_count_d;
    end
  end

  // Write at the fill position; read every cycle
  always_ff @(posedge clk_i) begin
    if (req_i.load && !req_i.clear) begin
      mem[load_count_q[IdxW-1:0]] <= wdata_i;
    end
    rd_data_q <= mem[rd_idx_i];
  end

  assign rd_data_o    = rd_data_q;
  assign load_count_o = load_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_count_q <= CntW'(PAGE_BYTES))
    else $error("page buffer fill count beyond page size");

  a_no_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_count_q == CntW'(PAGE_BYTES)) |-> !req_i.load)
    else $error("load into a full page buffer");

  a_clear_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clear |=> (load_count_q == '0))
    else $error("page buffer not emptied after clear");

endmodule

// File: hdl/i2cee_ctrl.sv
// Bus phase sequencer: next state and result for one transaction.
module i2cee_ctrl import i2cee_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 16,
  localparam int unsigned IdxW = $clog2(PAGE_BYTES),
  localparam int unsigned CntW = $clog2(PAGE_BYTES + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  i2cee_in_t       item_i,
  input  logic [7:0]      poll_limit_i,
  input  logic [6:0]      dev_addr_i,
  input  logic [CntW-1:0] load_count_i,
  input  logic [7:0]      buf_byte_i,
  output i2cee_buf_req_t  buf_req_o,
  output logic [IdxW-1:0] rd_idx_o,
  output i2cee_out_t      res_o
);

  function automatic logic [255:0][7:0] page_ofs_tbl();
    logic [255:0][7:0] t;
    logic [7:0]        o;
    o = '0;
    for (int i = 0; i < 256; i++) begin
      t[i] = o;
      o = (o == 8'(PAGE_BYTES - 1)) ? 8'd0 : o + 8'd1;
    end
    return t;
  endfunction

  localparam logic [255:0][7:0] PageOfs = page_ofs_tbl();
  localparam logic [8:0]        PageW   = 9'(PAGE_BYTES);

  i2cee_phase_e  phase_q, phase_d;
  i2cee_stage_e  stage_q, stage_d;
  logic [1:0]    quarter_q, quarter_d;
  logic [3:0]    bit_q, bit_d;
  logic [7:0]    byte_q, byte_d;
  logic [7:0]    shift_q, shift_d;
  logic [7:0]    ack_q, ack_d;
  logic [7:0]    addr_q, addr_d;
  logic [7:0]    len_q, len_d;
  logic          is_read_q, is_read_d;
  i2cee_status_e final_q, final_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;

  logic       idle;
  logic       last;
  logic [1:0] q;
  logic [3:0] bit_inc;
  logic [7:0] byte_inc;
  logic [7:0] ack_inc;
  logic [8:0] span;
  logic       bad_write;

  assign idle     = (phase_q == PH_IDLE);
  assign q        = quarter_q;
  assign bit_inc  = bit_q + 4'd1;
  assign byte_inc = byte_q + 8'd1;
  assign ack_inc  = ack_q + 8'd1;
  assign last     = ({1'b0, byte_q} + 9'd1) >= {1'b0, len_q};
  assign span     = {1'b0, PageOfs[item_i.word_address]} + {1'b0, item_i.length};
  assign bad_write = (item_i.length == 8'd0) || ({1'b0, item_i.length} > PageW) ||
                     (item_i.length > 8'(load_count_i)) || (span > PageW);

  // Prefetch the next buffer byte; stable for a whole byte on the bus
  always_comb begin
    rd_idx_o = '0;
    if (stage_q != STG_ADDR && {1'b0, byte_inc} < PageW) begin
      rd_idx_o = byte_inc[IdxW-1:0];
    end
  end

  always_comb begin
    phase_d   = phase_q;
    stage_d   = stage_q;
    quarter_d = quarter_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    ack_d     = ack_q;
    addr_d    = addr_q;
    len_d     = len_q;
    is_read_d = is_read_q;
    final_d   = final_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    buf_req_o = '0;
    res_o     = '0;

    if (accept_i) begin
      case (item_i.operation)
        OP_TICK: begin
          if (!idle) begin
            quarter_d = q + 2'd1;
            case (phase_q)
              PH_START: begin
                scl_d = (q == 2'd1) || (q == 2'd2);
                sda_d = !q[1];
                if (q == 2'd3) begin
                  phase_d = PH_SEND;
                  shift_d = {dev_addr_i, stage_q == STG_DEVR};
                  bit_d   = '0;
                end
              end
              PH_SEND: begin
                scl_d = (q == 2'd1) || (q == 2'd2);
                sda_d = |(shift_q & MSB_MASK);
                if (q == 2'd3) begin
                  shift_d = {shift_q[6:0], 1'b0};
                  bit_d   = bit_inc;
                  if (bit_inc >= 4'd8) begin
                    phase_d = PH_ACK;
                    ack_d   = '0;
                  end
                end
              end
              PH_ACK: begin
                if (!q[1]) begin
                  scl_d = q[0];
                  sda_d = 1'b1;
                end else if (q == 2'd2) begin
                  scl_d = 1'b1;
                  sda_d = 1'b1;
                  if (item_i.sda_sample) begin
                    ack_d = ack_inc;
                    if (ack_inc >= poll_limit_i) begin
                      phase_d   = PH_STOP;
                      final_d   = ST_NO_ACK;
                      quarter_d = '0;
                    end else begin
                      quarter_d = 2'd2;
                    end
                  end
                end else begin
                  scl_d = 1'b0;
                  sda_d = 1'b0;
                  case (stage_q)
                    STG_DEVW: begin
                      stage_d = STG_ADDR;
                      phase_d = PH_SEND;
                      shift_d = addr_q;
                      bit_d   = '0;
                    end
                    STG_ADDR: begin
                      if (is_read_q) begin
                        stage_d = STG_DEVR;
                        phase_d = PH_START;
                      end else begin
                        stage_d = STG_DATA;
                        byte_d  = '0;
                        phase_d = PH_SEND;
                        shift_d = buf_byte_i;
                        bit_d   = '0;
                      end
                    end
                    STG_DATA: begin
                      byte_d = byte_inc;
                      if (byte_inc >= len_q) begin
                        phase_d   = PH_STOP;
                        final_d   = ST_OK;
                        quarter_d = '0;
                      end else begin
                        phase_d = PH_SEND;
                        shift_d = buf_byte_i;
                        bit_d   = '0;
                      end
                    end
                    default: begin
                      phase_d = PH_RECV;
                      byte_d  = '0;
                      bit_d   = '0;
                      shift_d = '0;
                    end
                  endcase
                end
              end
              PH_RECV: begin
                scl_d = (q == 2'd1) || (q == 2'd2);
                sda_d = 1'b1;
                if (q == 2'd2) begin
                  shift_d = {shift_q[6:0], item_i.sda_sample};
                end
                if (q == 2'd3) begin
                  bit_d = bit_inc;
                  if (bit_inc >= 4'd8) begin
                    res_o.read_data  = shift_q;
                    res_o.read_valid = 1'b1;
                    res_o.read_last  = last;
                    phase_d          = PH_MACK;
                  end
                end
              end
              PH_MACK: begin
                scl_d = (q == 2'd1) || (q == 2'd2);
                sda_d = (q == 2'd3) || last;
                if (q == 2'd3) begin
                  byte_d = byte_inc;
                  if (last) begin
                    phase_d   = PH_STOP;
                    final_d   = ST_OK;
                    quarter_d = '0;
                  end else begin
                    phase_d = PH_RECV;
                    bit_d   = '0;
                    shift_d = '0;
                  end
                end
              end
              PH_STOP: begin
                scl_d = (q != 2'd0);
                sda_d = q[1];
                if (q == 2'd3) begin
                  res_o.done_res = 1'b1;
                  res_o.status   = final_q;
                  phase_d        = PH_IDLE;
                end
              end
              default: begin
                phase_d   = PH_IDLE;
                quarter_d = '0;
                scl_d     = 1'b1;
                sda_d     = 1'b1;
              end
            endcase
          end
        end
        OP_LOAD: begin
          if (idle && ({1'b0, 8'(load_count_i)} < PageW)) begin
            buf_req_o.load = 1'b1;
          end
        end
        OP_WRITE: begin
          if (idle) begin
            if (bad_write) begin
              res_o.done_res = 1'b1;
              res_o.status   = ST_BAD_ARG;
            end else begin
              buf_req_o.clear = 1'b1;
              addr_d    = item_i.word_address;
              len_d     = item_i.length;
              is_read_d = 1'b0;
              stage_d   = STG_DEVW;
              phase_d   = PH_START;
              quarter_d = '0;
            end
          end
        end
        OP_READ: begin
          if (idle) begin
            if (item_i.length == 8'd0) begin
              res_o.done_res = 1'b1;
              res_o.status   = ST_BAD_ARG;
            end else begin
              addr_d    = item_i.word_address;
              len_d     = item_i.length;
              is_read_d = 1'b1;
              stage_d   = STG_DEVW;
              phase_d   = PH_START;
              quarter_d = '0;
            end
          end
        end
        default: ;
      endcase
    end

    res_o.scl         = scl_d;
    res_o.sda_release = sda_d;
    res_o.busy_res    = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      stage_q   <= STG_DEVW;
      quarter_q <= '0;
      bit_q     <= '0;
      byte_q    <= '0;
      shift_q   <= '0;
      ack_q     <= '0;
      addr_q    <= '0;
      len_q     <= '0;
      is_read_q <= 1'b0;
      final_q   <= ST_OK;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      stage_q   <= stage_d;
      quarter_q <= quarter_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      shift_q   <= shift_d;
      ack_q     <= ack_d;
      addr_q    <= addr_d;
      len_q     <= len_d;
      is_read_q <= is_read_d;
      final_q   <= final_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

  a_rx_from_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.read_valid |-> (phase_q == PH_RECV) && is_read_q)
    else $error("received byte reported outside a receive phase");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> !res_o.busy_res)
    else $error("done reported while still busy");

  a_ack_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.operation == OP_TICK && phase_q == PH_ACK &&
     quarter_q == 2'd2 && item_i.sda_sample)
    |=> (phase_q == PH_STOP) || (phase_q == PH_ACK && quarter_q == 2'd2))
    else $error("missing acknowledge neither held nor timed out");

  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd8)
    else $error("bit counter overran a byte");

endmodule

// File: hdl/i2c_eeprom_page_master.sv
// Top level of the I2C EEPROM page master: config registers and result register.
//
// Usage: every transaction on the input channel carries one operation. A tick
// advances the bus by one quarter-bit phase and supplies the sampled SDA level;
// a load appends write_data to the page buffer; a page write or block read
// command starts a bus sequence at word_address for length bytes. Each input
// transaction yields exactly one result transaction with the SCL and SDA line
// levels after that item, busy and done flags, a status code and, during reads,
// a received byte with its valid and last flags.
// The result is registered and appears in the cycle after the input is accepted.
// Throughput: one item per cycle while results are taken; the whole per-item
// step is a single pass of the phase sequencer between the accept edge and the
// result register. Stall: while a result waits and the receiver holds ready
// low, the input channel stops taking items; when the result is taken the next
// item may be accepted in the same cycle.
// Reset: the sequencer returns to idle with both lines released, the page
// buffer is emptied, and ack_poll_limit and device_address take 10 and 80.
// Configuration writes are registered and take effect in the cycle after their
// transaction, and should only be issued while the block is idle.
module i2c_eeprom_page_master import i2cee_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i2cee_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2cee_out_t           out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  localparam int unsigned IdxW = $clog2(PAGE_BYTES);
  localparam int unsigned CntW = $clog2(PAGE_BYTES + 1);

  logic           in_fire;
  logic           out_valid_q, out_valid_d;
  i2cee_out_t     out_q;
  i2cee_out_t     res;
  logic [7:0]     poll_limit_q, poll_limit_d;
  logic [6:0]     dev_addr_q, dev_addr_d;
  i2cee_buf_req_t buf_req;
  logic [IdxW-1:0] rd_idx;
  logic [7:0]     buf_byte;
  logic [CntW-1:0] load_count;

  // Take a new item whenever the result register is empty or being drained
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  i2cee_page_buf #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_page_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (buf_req),
    .wdata_i     (in_data_i.write_data),
    .rd_idx_i    (rd_idx),
    .rd_data_o   (buf_byte),
    .load_count_o(load_count)
  );

  i2cee_ctrl #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .item_i      (in_data_i),
    .poll_limit_i(poll_limit_q),
    .dev_addr_i  (dev_addr_q),
    .load_count_i(load_count),
    .buf_byte_i  (buf_byte),
    .buf_req_o   (buf_req),
    .rd_idx_o    (rd_idx),
    .res_o       (res)
  );

  // Config writes; drop unknown indexes
  always_comb begin
    poll_limit_d = poll_limit_q;
    dev_addr_d   = dev_addr_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ACK_POLL_LIMIT) begin
        poll_limit_d = cfg_data_i;
      end else if (cfg_index_i == CFG_DEVICE_ADDRESS) begin
        dev_addr_d = cfg_data_i[6:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= ACK_POLL_RESET;
      dev_addr_q   <= DEV_ADDR_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      poll_limit_q <= poll_limit_d;
      dev_addr_q   <= dev_addr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_fire)
    else $error("pending result overwritten");

  a_flags_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.done_res || out_q.status == ST_OK) &&
                    (out_q.read_valid || !out_q.read_last))
    else $error("status or last flag set without its qualifier");

endmodule

// File: dv/tb_i2c_eeprom_page_master.sv
// Self-checking testbench for the I2C EEPROM page master, with prediction and random stimulus.
`timescale 1ns / 100ps

module tb_i2c_eeprom_page_master;
  import i2cee_pkg::*;

  localparam int PageBytes  = 16;
  // Input items per random phase; each phase runs at least one bus episode.
  localparam int PhaseItems = 60;

  // Bus-level state of the master, mirrored item by item by the predictor.
  typedef struct packed {
    logic [7:0]                 poll_limit;
    logic [6:0]                 dev_addr;
    i2cee_phase_e               phase;
    logic [1:0]                 quarter;
    logic [3:0]                 bit_cnt;
    logic [7:0]                 byte_cnt;
    logic [7:0]                 shifter;
    logic [7:0]                 poll_cnt;
    logic [PageBytes-1:0][7:0]  page;
    logic [4:0]                 fill;
    logic [7:0]                 hold_addr;
    logic [7:0]                 hold_len;
    i2cee_stage_e               stage;
    logic                       is_read;
    i2cee_status_e              end_status;
    logic                       scl;
    logic                       sda;
  } bus_model_t;

  // How the emulated memory answers acknowledge polls.
  typedef enum logic [1:0] {
    ACK_GOOD,
    ACK_SLOW,
    ACK_NONE
  } ack_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  i2cee_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  i2cee_out_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i  = '0;

  // plan_m runs ahead while stimulus is built; check_m follows accepted input transactions.
  bus_model_t plan_m;
  bus_model_t check_m;
  i2cee_in_t  pending_q[$];
  i2cee_out_t expected_q[$];

  int error_count = 0;
  int result_idx  = 0;
  int item_count  = 0;
  int send_gap    = 0;
  int send_calm   = 0;
  int recv_hold   = 0;
  int recv_calm   = 0;
  int recv_cycles = 0;
  bit long_hold_done = 1'b0;

  i2c_eeprom_page_master #(
    .PAGE_BYTES(PageBytes)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hang guard: far beyond the slowest legal run, including every long stall.
  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  function automatic bus_model_t fresh_model();
    bus_model_t m;
    m            = '0;
    m.poll_limit = ACK_POLL_RESET;
    m.dev_addr   = DEV_ADDR_RESET;
    m.phase      = PH_IDLE;
    m.stage      = STG_DEVW;
    m.end_status = ST_OK;
    m.scl        = 1'b1;
    m.sda        = 1'b1;
    return m;
  endfunction

  // Load a byte into the shifter and start clocking it out, MSB first.
  function automatic bus_model_t shift_out_byte(bus_model_t m, logic [7:0] b);
    m.phase   = PH_SEND;
    m.shifter = b;
    m.bit_cnt = '0;
    return m;
  endfunction

  function automatic bus_model_t head_for_stop(bus_model_t m, i2cee_status_e st);
    m.phase      = PH_STOP;
    m.end_status = st;
    m.quarter    = '0;
    return m;
  endfunction

  // Advance the model by one input item and produce the result it causes.
  task automatic eeprom_bus_step(inout bus_model_t m, input i2cee_in_t it,
                                 output i2cee_out_t r);
    logic [1:0] q;
    logic       last;
    logic       idle;
    int         span;
    r    = '0;
    idle = (m.phase == PH_IDLE);
    span = int'(it.word_address) % PageBytes + int'(it.length);
    case (it.operation)
      OP_TICK: begin
        if (!idle) begin
          q         = m.quarter;
          last      = ({1'b0, m.byte_cnt} + 9'd1) >= {1'b0, m.hold_len};
          m.quarter = q + 2'd1;
          case (m.phase)
            PH_START: begin
              m.scl = (q == 2'd1 || q == 2'd2);
              m.sda = (q <= 2'd1);
              if (q == 2'd3) m = shift_out_byte(m, {m.dev_addr, m.stage == STG_DEVR});
            end
            PH_SEND: begin
              m.scl = (q == 2'd1 || q == 2'd2);
              m.sda = (m.shifter & MSB_MASK) != 8'h00;
              if (q == 2'd3) begin
                m.shifter = m.shifter << 1;
                m.bit_cnt = m.bit_cnt + 4'd1;
                if (m.bit_cnt >= 4'd8) begin
                  m.phase    = PH_ACK;
                  m.poll_cnt = '0;
                end
              end
            end
            PH_ACK: begin
              if (q <= 2'd1) begin
                m.scl = q[0];
                m.sda = 1'b1;
              end else if (q == 2'd2) begin
                m.scl = 1'b1;
                m.sda = 1'b1;
                // Hold the high clock quarter until the slave pulls SDA low or the poll limit is reached.
                if (it.sda_sample) begin
                  m.poll_cnt = m.poll_cnt + 8'd1;
                  if (m.poll_cnt >= m.poll_limit) m = head_for_stop(m, ST_NO_ACK);
                  else m.quarter = 2'd2;
                end
              end else begin
                m.scl = 1'b0;
                m.sda = 1'b0;
                case (m.stage)
                  STG_DEVW: begin
                    m.stage = STG_ADDR;
                    m       = shift_out_byte(m, m.hold_addr);
                  end
                  STG_ADDR: begin
                    if (m.is_read) begin
                      m.stage = STG_DEVR;
                      m.phase = PH_START;
                    end else begin
                      m.stage    = STG_DATA;
                      m.byte_cnt = '0;
                      m          = shift_out_byte(m, m.page[0]);
                    end
                  end
                  STG_DATA: begin
                    m.byte_cnt = m.byte_cnt + 8'd1;
                    if (m.byte_cnt >= m.hold_len) m = head_for_stop(m, ST_OK);
                    else m = shift_out_byte(m, (m.byte_cnt < PageBytes) ?
                                               m.page[m.byte_cnt[3:0]] : 8'h00);
                  end
                  default: begin
                    m.phase    = PH_RECV;
                    m.byte_cnt = '0;
                    m.bit_cnt  = '0;
                    m.shifter  = '0;
                  end
                endcase
              end
            end
            PH_RECV: begin
              m.scl = (q == 2'd1 || q == 2'd2);
              m.sda = 1'b1;
              if (q == 2'd2) m.shifter = {m.shifter[6:0], it.sda_sample};
              if (q == 2'd3) begin
                m.bit_cnt = m.bit_cnt + 4'd1;
                if (m.bit_cnt >= 4'd8) begin
                  r.read_data  = m.shifter;
                  r.read_valid = 1'b1;
                  r.read_last  = last;
                  m.phase      = PH_MACK;
                end
              end
            end
            PH_MACK: begin
              // NACK the last byte of the block, ACK all others.
              m.scl = (q == 2'd1 || q == 2'd2);
              m.sda = (q == 2'd3) || last;
              if (q == 2'd3) begin
                m.byte_cnt = m.byte_cnt + 8'd1;
                if (last) begin
                  m = head_for_stop(m, ST_OK);
                end else begin
                  m.phase   = PH_RECV;
                  m.bit_cnt = '0;
                  m.shifter = '0;
                end
              end
            end
            PH_STOP: begin
              m.scl = (q >= 2'd1);
              m.sda = (q >= 2'd2);
              if (q == 2'd3) begin
                r.done_res = 1'b1;
                r.status   = m.end_status;
                m.phase    = PH_IDLE;
              end
            end
            default: begin
              m.phase   = PH_IDLE;
              m.quarter = '0;
              m.scl     = 1'b1;
              m.sda     = 1'b1;
            end
          endcase
        end
      end
      OP_LOAD: begin
        if (idle && m.fill < PageBytes) begin
          m.page[m.fill[3:0]] = it.write_data;
          m.fill              = m.fill + 5'd1;
        end
      end
      OP_WRITE: begin
        if (idle) begin
          if (it.length == 8'd0 || it.length > PageBytes || it.length > m.fill ||
              span > PageBytes) begin
            r.done_res = 1'b1;
            r.status   = ST_BAD_ARG;
          end else begin
            m.fill      = '0;
            m.hold_addr = it.word_address;
            m.hold_len  = it.length;
            m.is_read   = 1'b0;
            m.stage     = STG_DEVW;
            m.phase     = PH_START;
            m.quarter   = '0;
          end
        end
      end
      default: begin
        if (idle) begin
          if (it.length == 8'd0) begin
            r.done_res = 1'b1;
            r.status   = ST_BAD_ARG;
          end else begin
            m.hold_addr = it.word_address;
            m.hold_len  = it.length;
            m.is_read   = 1'b1;
            m.stage     = STG_DEVW;
            m.phase     = PH_START;
            m.quarter   = '0;
          end
        end
      end
    endcase
    r.scl         = m.scl;
    r.sda_release = m.sda;
    r.busy_res    = (m.phase != PH_IDLE);
  endtask

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Queue one item for the driver and advance the planning copy of the model.
  task automatic push_item(i2cee_op_e op, logic sda, logic [7:0] addr, logic [7:0] len,
                           logic [7:0] wdat);
    i2cee_in_t  it;
    i2cee_out_t unused;
    it.operation    = op;
    it.sda_sample   = sda;
    it.word_address = addr;
    it.length       = len;
    it.write_data   = wdat;
    item_count++;
    eeprom_bus_step(plan_m, it, unused);
    pending_q.push_back(it);
  endtask

  task automatic push_load(logic [7:0] wdat);
    push_item(OP_LOAD, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), wdat);
  endtask

  // Clock the bus until the transfer ends, answering polls per the given mode.
  // With noise on, sprinkle commands in that the busy block has to ignore.
  task automatic run_bus(ack_mode_e mode, bit noisy);
    logic s;
    while (plan_m.phase != PH_IDLE) begin
      if (noisy && $urandom_range(0, 24) == 0) begin
        push_item(i2cee_op_e'(2'($urandom_range(1, 3))), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else begin
        s = 1'($urandom_range(0, 1));
        if (plan_m.phase == PH_ACK && plan_m.quarter == 2'd2) begin
          case (mode)
            ACK_GOOD: s = 1'b0;
            ACK_SLOW: s = ($urandom_range(0, 2) == 0);
            default:  s = 1'b1;
          endcase
        end
        push_item(OP_TICK, s, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every queued item is taken and every result is back, then drain.
  task automatic settle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic wait_cfg_accept();
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  // Write both registers on an idle block; optionally poke the unused indexes too.
  task automatic write_regs(logic [7:0] limit, logic [6:0] dev, bit with_unused);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ACK_POLL_LIMIT;
    cfg_data_i  <= limit;
    wait_cfg_accept();
    cfg_index_i <= CFG_DEVICE_ADDRESS;
    cfg_data_i  <= {1'($urandom_range(0, 1)), dev};
    wait_cfg_accept();
    if (with_unused) begin
      cfg_index_i <= 2'd2;
      cfg_data_i  <= 8'($urandom_range(0, 255));
      wait_cfg_accept();
      cfg_index_i <= 2'd3;
      cfg_data_i  <= 8'($urandom_range(0, 255));
      wait_cfg_accept();
    end
    cfg_valid_i       <= 1'b0;
    plan_m.poll_limit  = limit;
    plan_m.dev_addr    = dev;
    check_m.poll_limit = limit;
    check_m.dev_addr   = dev;
  endtask

  // One random bus episode: mostly well-formed page writes and block reads.
  task automatic random_transaction();
    int        pick;
    int        n;
    int        len;
    int        off;
    ack_mode_e mode;
    bit        noisy;
    pick  = $urandom_range(0, 99);
    n     = $urandom_range(0, 99);
    mode  = (n < 75) ? ACK_GOOD : (n < 95) ? ACK_SLOW : ACK_NONE;
    noisy = ($urandom_range(0, 3) == 0);
    if (pick < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
      repeat (n) push_load(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 6) != 0 && plan_m.fill != 0) begin
        len = $urandom_range(1, int'(plan_m.fill));
        off = $urandom_range(0, PageBytes - len);
        push_item(OP_WRITE, 1'($urandom_range(0, 1)),
                  {4'($urandom_range(0, 15)), 4'(off)}, 8'(len),
                  8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 255);
        push_item(OP_WRITE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 8'(len),
                  8'($urandom_range(0, 255)));
      end
    end else if (pick < 80) begin
      n   = $urandom_range(0, 99);
      len = (n < 3) ? 0 : (n < 80) ? $urandom_range(1, 2) :
            (n < 97) ? $urandom_range(3, 5) : $urandom_range(17, 20);
      push_item(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 8'(len),
                8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 6)) push_load(8'($urandom_range(0, 255)));
    end else begin
      // Idle ticks, then a command with arbitrary address and a short length.
      repeat ($urandom_range(1, 4)) push_item(OP_TICK, 1'($urandom_range(0, 1)),
                                              8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255)));
      push_item(i2cee_op_e'(2'($urandom_range(2, 3))), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)),
                8'($urandom_range(0, 255)));
    end
    if (plan_m.phase != PH_IDLE) run_bus(mode, noisy);
  endtask

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (error_count < 200) $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  task automatic field_check(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h", result_idx, what,
                                got, want));
  endtask

  // ------------------------------------------------------------------------
  // Input driver: feed queued items, with random gaps between transactions
  // ------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_items
    i2cee_out_t want;
    int         k;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // Predict on every accepted input transaction.
      if (in_valid_i && in_ready_o) begin
        eeprom_bus_step(check_m, in_data_i, want);
        expected_q.push_back(want);
      end
      // Only touch valid and payload once the slot is free.
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data_i  <= pending_q.pop_front();
          in_valid_i <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            k = $urandom_range(0, 99);
            if (k < 60) send_gap = 0;
            else if (k < 90) send_gap = $urandom_range(1, 3);
            else if (k < 97) send_gap = $urandom_range(4, 12);
            else if (k < 99) send_gap = $urandom_range(20, 60);
            else send_calm = $urandom_range(100, 400);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor and receiver back-pressure
  // ------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch_results
    i2cee_out_t want;
    int         k;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
          want = expected_q.pop_front();
          field_check("scl", 8'(out_data_o.scl), 8'(want.scl));
          field_check("sda_release", 8'(out_data_o.sda_release), 8'(want.sda_release));
          field_check("busy_res", 8'(out_data_o.busy_res), 8'(want.busy_res));
          field_check("done_res", 8'(out_data_o.done_res), 8'(want.done_res));
          field_check("status", 8'(out_data_o.status), 8'(want.status));
          field_check("read_data", out_data_o.read_data, want.read_data);
          field_check("read_valid", 8'(out_data_o.read_valid), 8'(want.read_valid));
          field_check("read_last", 8'(out_data_o.read_last), 8'(want.read_last));
        end
        result_idx++;
      end
      recv_cycles++;
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && recv_cycles > 200 && pending_q.size() > 64) begin
        // Hold off long enough for the block to back up and stall its input.
        long_hold_done = 1'b1;
        recv_hold      = 300;
        out_ready_i   <= 1'b0;
      end else if (recv_calm > 0) begin
        recv_calm--;
        out_ready_i <= 1'b1;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 8) recv_hold = $urandom_range(1, 3);
        else if (k < 10) recv_hold = $urandom_range(10, 40);
        else if (k == 99) recv_calm = $urandom_range(100, 400);
        out_ready_i <= (recv_hold == 0);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------

  initial begin
    int idx;
    int phase_no;
    int op_target;
    plan_m  = fresh_model();
    check_m = fresh_model();

    // Directed: idle tick, refused commands, buffer overfill, each bus path.
    push_item(OP_TICK, 1'b0, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_WRITE, 1'b1, 8'h00, 8'd1, 8'h00);   // nothing loaded yet
    push_item(OP_READ, 1'b0, 8'h10, 8'd0, 8'h00);    // zero-length read
    for (idx = 0; idx <= PageBytes; idx++) begin
      // Last load lands on a full buffer and is dropped.
      push_load((idx == 0) ? 8'h00 : (idx == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
    end
    push_item(OP_WRITE, 1'b0, 8'h00, 8'd255, 8'h00); // longer than a page
    push_item(OP_WRITE, 1'b0, 8'h0F, 8'd2, 8'h00);   // crosses a page boundary
    push_item(OP_WRITE, 1'b0, 8'h00, 8'd0, 8'h00);   // zero-length write
    push_item(OP_WRITE, 1'b0, 8'hFE, 8'd2, 8'h00);   // ends exactly on a page boundary
    run_bus(ACK_SLOW, 1'b1);
    push_item(OP_READ, 1'b0, 8'hFF, 8'd2, 8'h00);
    run_bus(ACK_GOOD, 1'b0);
    push_item(OP_READ, 1'b0, 8'h00, 8'd1, 8'h00);    // device never answers
    run_bus(ACK_NONE, 1'b0);

    // Poll limit zero: the first failed sample ends the transfer.
    write_regs(8'd0, 7'h55, 1'b0);
    push_load(8'hA5);
    push_item(OP_WRITE, 1'b0, 8'h03, 8'd1, 8'h00);
    run_bus(ACK_NONE, 1'b0);

    // Random phases, each under a different register setting.
    for (phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: write_regs(8'd1, 7'd0, 1'b0);
        1: write_regs(8'd255, 7'd127, 1'b0);
        2: write_regs(8'd0, 7'($urandom_range(0, 127)), 1'b1);
        3: write_regs(8'($urandom_range(2, 30)), 7'($urandom_range(0, 127)), 1'b1);
        default: write_regs(ACK_POLL_RESET, DEV_ADDR_RESET, 1'b0);
      endcase
      op_target = item_count + PhaseItems;
      while (item_count < op_target) random_transaction();
    end

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
